### rtl/core/usc_pkg.sv
// Shared types, constants and the control store for the seconds-to-calendar converter.
// Used by usc_seq, usc_dp and unix_seconds_to_calendar; depends on nothing.
package usc_pkg;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_DIV,
    OP_SAVE_DAY,
    OP_SAVE_WD,
    OP_SAVE_HR,
    OP_SAVE_MS,
    OP_REM,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_WEEK,
    DIV_HOUR,
    DIV_MIN
  } dsel_t;

  typedef struct packed {
    op_t             op;
    dsel_t           dsel;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } ctrl_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } stat_t;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [11:0] SKIP_LEAP_YEAR = 12'd2100;
  localparam logic [3:0]  LAST_MONTH     = 4'd12;
  localparam logic [3:0]  FEBRUARY       = 4'd2;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;
  localparam logic [8:0]  DAYS_LEAP      = 9'd366;
  localparam logic [8:0]  DAYS_COMMON    = 9'd365;

  // odd parts of the divisors after the power-of-two shift, and their reciprocals
  localparam logic [9:0]  ODD_DAY    = 10'd675;
  localparam logic [2:0]  DAYS_WEEK  = 3'd7;
  localparam logic [7:0]  ODD_HOUR   = 8'd225;
  localparam logic [3:0]  ODD_MIN    = 4'd15;
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [16:0] RECIP_WEEK = 17'd74899;     // ceil(2^19 / 7)
  localparam logic [13:0] RECIP_HOUR = 14'd9321;      // ceil(2^21 / 225)
  localparam logic [10:0] RECIP_MIN  = 11'd1093;      // ceil(2^14 / 15)

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = '{OP_WAIT_IN,  DIV_DAY,  4'd1};
      4'd1:  w = '{OP_DIV,      DIV_DAY,  4'd2};
      4'd2:  w = '{OP_SAVE_DAY, DIV_DAY,  4'd3};
      4'd3:  w = '{OP_REM,      DIV_DAY,  4'd4};
      4'd4:  w = '{OP_DIV,      DIV_WEEK, 4'd5};
      4'd5:  w = '{OP_SAVE_WD,  DIV_WEEK, 4'd6};
      4'd6:  w = '{OP_REM,      DIV_WEEK, 4'd7};
      4'd7:  w = '{OP_DIV,      DIV_HOUR, 4'd8};
      4'd8:  w = '{OP_SAVE_HR,  DIV_HOUR, 4'd9};
      4'd9:  w = '{OP_REM,      DIV_HOUR, 4'd10};
      4'd10: w = '{OP_DIV,      DIV_MIN,  4'd11};
      4'd11: w = '{OP_SAVE_MS,  DIV_MIN,  4'd12};
      4'd12: w = '{OP_REM,      DIV_MIN,  4'd13};
      4'd13: w = '{OP_YEAR,     DIV_DAY,  4'd14};
      4'd14: w = '{OP_MONTH,    DIV_DAY,  4'd15};
      4'd15: w = '{OP_EMIT,     DIV_DAY,  4'd0};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] n;
    unique case (mon)
      FEBRUARY:                  n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/usc_seq.sv
// Microcode sequencer: step counter and control store lookup.
// Depends on usc_pkg; drives usc_dp through ctrl_t.
module usc_seq
  import usc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  in_ready
);

  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            done;

  assign uw        = ucode(pc);
  assign ctrl.op   = uw.op;
  assign ctrl.dsel = uw.dsel;
  assign in_ready  = (uw.op == OP_WAIT_IN);

  always_comb begin
    unique case (uw.op)
      OP_WAIT_IN: done = in_valid;
      OP_YEAR:    done = !stat.year_more;
      OP_MONTH:   done = !stat.month_more;
      OP_EMIT:    done = out_free;
      default:    done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (done) begin
      pc <= uw.target;
    end
  end

endmodule

### rtl/core/usc_dp.sv
// Datapath: reciprocal-multiply splitting, year and month count-off, result fields.
// Depends on usc_pkg; controlled by usc_seq.
module usc_dp
  import usc_pkg::*;
(
  input  logic        clk,
  input  ctrl_t       ctrl,
  input  logic        in_valid,
  input  logic [31:0] unix_seconds,
  output stat_t       stat,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [31:0] secs;
  logic [50:0] prod;
  logic [16:0] tod;
  logic [15:0] days;
  logic [12:0] quo;
  logic [11:0] rhr;
  logic [11:0] yr;
  logic [3:0]  mon;
  logic [2:0]  wd;
  logic [4:0]  hr;
  logic [5:0]  mn;
  logic [5:0]  sc;

  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [24:0] day_left;
  logic [15:0] wk_left;
  logic [12:0] hr_left;
  logic [9:0]  mn_left;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  always_comb begin
    unique case (ctrl.dsel)
      DIV_DAY: begin
        mul_a = secs[31:7];
        mul_b = RECIP_DAY;
      end
      DIV_WEEK: begin
        mul_a = {9'd0, days};
        mul_b = {9'd0, RECIP_WEEK};
      end
      DIV_HOUR: begin
        mul_a = {12'd0, tod[16:4]};
        mul_b = {12'd0, RECIP_HOUR};
      end
      DIV_MIN: begin
        mul_a = {15'd0, rhr[11:2]};
        mul_b = {15'd0, RECIP_MIN};
      end
    endcase
  end

  assign day_left = secs[31:7] - ({9'd0, days} * {15'd0, ODD_DAY});
  assign wk_left  = days - ({3'd0, quo} * {13'd0, DAYS_WEEK});
  assign hr_left  = tod[16:4] - ({8'd0, hr} * {5'd0, ODD_HOUR});
  assign mn_left  = rhr[11:2] - ({4'd0, mn} * {6'd0, ODD_MIN});

  assign leap = (yr[1:0] == 2'b00) && (yr != SKIP_LEAP_YEAR);
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_len(mon, leap);

  assign stat.year_more  = (days >= {7'd0, ylen});
  assign stat.month_more = (days >= {11'd0, mlen}) && (mon != LAST_MONTH);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_WAIT_IN: begin
        if (in_valid) begin
          secs <= unix_seconds;
          yr   <= EPOCH_YEAR;
          mon  <= 4'd1;
        end
      end
      OP_DIV: begin
        prod <= {26'd0, mul_a} * {25'd0, mul_b};
      end
      OP_SAVE_DAY: begin
        days <= prod[50:35];
      end
      OP_SAVE_WD: begin
        quo <= prod[31:19];
      end
      OP_SAVE_HR: begin
        hr <= prod[25:21];
      end
      OP_SAVE_MS: begin
        mn <= prod[19:14];
      end
      OP_REM: begin
        unique case (ctrl.dsel)
          DIV_DAY: begin
            tod <= {day_left[9:0], secs[6:0]};
          end
          DIV_WEEK: begin
            wd <= (wk_left[2:0] >= 3'd3) ? wk_left[2:0] - 3'd3
                                         : wk_left[2:0] + EPOCH_WEEKDAY;
          end
          DIV_HOUR: begin
            rhr <= {hr_left[7:0], tod[3:0]};
          end
          DIV_MIN: begin
            sc <= {mn_left[3:0], rhr[1:0]};
          end
        endcase
      end
      OP_YEAR: begin
        if (stat.year_more) begin
          days <= days - {7'd0, ylen};
          yr   <= yr + 1'b1;
        end
      end
      OP_MONTH: begin
        if (stat.month_more) begin
          days <= days - {11'd0, mlen};
          mon  <= mon + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign year    = yr;
  assign month   = mon;
  assign day     = days[4:0] + 5'd1;
  assign weekday = wd;
  assign hour    = hr;
  assign minute  = mn;
  assign second  = sc;

endmodule

### rtl/core/unix_seconds_to_calendar.sv
// Unix seconds to Gregorian date, time of day and weekday; top level.
// Depends on usc_pkg, usc_seq and usc_dp.
// The year count-off loop walks Y = years past 1970 (0..136) and the month count-off loop
//   M = months past January (0..11), so the conversion time depends on the date.
// New words wait until the last result is handed on; reciprocal multiplies split the seconds.
// Reset: rst clears the step counter and the output valid; no result is pending after it.
module unix_seconds_to_calendar
  import usc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] unix_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // year, month, day, weekday, hour, minute, second, zero pad
);

  ctrl_t       ctrl;
  stat_t       stat;
  logic        out_free;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  assign out_free = !m_tvalid || m_tready;

  usc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (s_tready)
  );

  usc_dp u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .in_valid     (s_tvalid),
    .unix_seconds (s_tdata),
    .stat         (stat),
    .year         (year),
    .month        (month),
    .day          (day),
    .weekday      (weekday),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && out_free) begin
      m_tdata <= {7'd0, second, minute, hour, weekday, day, month, year};
    end
  end

endmodule

### tb/tb.sv
// Testbench for unix_seconds_to_calendar: streams second counts in, predicts each calendar word
// in a scoreboard class and checks every result field; random gaps and stalls on both sides.
// Depends only on the RTL top level; no files, no arguments.
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int QUIET_FROM     = 1000;
  localparam int LAST_DAY       = 49709;
  localparam int SECS_PER_DAY   = 86400;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t dates_due[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    static function bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function calendar_t to_calendar(input logic [31:0] secs);
      calendar_t   c;
      int unsigned rest, span, zy, zm, wd, yr, mon;
      bit          leap;
      byte unsigned days_in[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      rest = secs;
      c.second = rest % 60;
      rest = rest / 60;
      c.minute = rest % 60;
      rest = rest / 60;
      c.hour = rest % 24;
      rest = rest / 24;
      yr = 1970;
      span = leap_year(yr) ? 366 : 365;
      while (rest >= span) begin
        rest -= span;
        yr++;
        span = leap_year(yr) ? 366 : 365;
      end
      leap = leap_year(yr);
      mon = 1;
      span = days_in[0];
      while (rest >= span && mon < 12) begin
        rest -= span;
        mon++;
        span = days_in[mon-1] + ((mon == 2 && leap) ? 1 : 0);
      end
      c.year  = yr;
      c.month = mon;
      c.day   = rest + 1;
      zy = yr;
      zm = mon;
      if (zm < 3) begin
        zm += 12;
        zy--;
      end
      wd = (rest + 1 + (13 * (zm + 1)) / 5 + zy + zy / 4 - zy / 100 + zy / 400) % 7;
      c.weekday = (wd + 6) % 7;
      return c;
    endfunction

    function void note(input logic [31:0] secs);
      dates_due.push_back(to_calendar(secs));
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check(input logic [47:0] word);
      calendar_t want, got;
      if (dates_due.size() == 0) begin
        $error("result word with nothing expected: %h", word);
        errors++;
        return;
      end
      want = dates_due.pop_front();
      got  = word[40:0];
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("pad", 0, word[47:41]);
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  bit                 quiet = 1'b0;
  int                 idle_cycles = 0;
  calendar_scoreboard sb = new();

  unix_seconds_to_calendar u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : sink_ready
    int n;
    forever begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (n) @(posedge clk);
      if (!quiet) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send_secs(input logic [31:0] secs);
    s_tdata  <= secs;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(secs);
  endtask

  task automatic hold_sender(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.dates_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_secs();
    int unsigned days, yr, y;
    case ($urandom_range(0, 3))
      0: begin
        days = $urandom_range(0, LAST_DAY);
        return days * SECS_PER_DAY + ($urandom_range(0, 1) ? 86399 : $urandom_range(0, 3));
      end
      1: begin
        // land near the end of February of a random year
        yr = $urandom_range(1970, 2105);
        days = 0;
        for (y = 1970; y < yr; y++) days += calendar_scoreboard::leap_year(y) ? 366 : 365;
        days += 58 + $urandom_range(0, 1);
        if ($urandom_range(0, 1)) days -= $urandom_range(0, 1);
        return days * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] corner[] = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd3599, 32'd86399, 32'd31535999, 32'd31536000,
      32'd68169600, 32'd68255999, 32'd94694399, 32'd946684799, 32'd951782400,
      32'd951868800, 32'd4102444799, 32'd4107456000, 32'd4107542400, 32'd2147483647,
      32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE
    };
    int i;
    do @(posedge clk); while (rst);
    foreach (corner[k]) begin
      send_secs(corner[k]);
      if ($urandom_range(0, 2) == 0) hold_sender($urandom_range(1, 15));
    end
    drain();
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      if (i == RANDOM_WORDS / 2) drain();
      send_secs(pick_secs());
      if (!quiet && ((i / 64) % 3 != 0) && $urandom_range(0, 2) == 0) begin
        hold_sender($urandom_range(1, 15));
      end
    end
    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
